// File: src/llmb_pkg.sv
// ----------------------------------------------------------------------------
// Layered LED matrix buffer package
// Geometry constants, command codes, item types and a shared helper function.
// ----------------------------------------------------------------------------
package llmb_pkg;

  localparam int ROWS     = 8;
  localparam int COLS     = 8;
  localparam int COLORS   = 3;
  localparam int LEVELS   = 4;
  localparam int NLEDS    = ROWS * COLS;

  localparam int COLOR_W  = 3;   // width of the colour mask field
  localparam int PB_W     = 8;   // width of the returned row bitmap
  localparam int LT_W     = LEVELS * (1 + COLOR_W);
  localparam int FR_W     = COLORS * COLS;
  localparam int LED_AW   = (NLEDS > 1) ? $clog2(NLEDS) : 1;
  localparam int FR_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_AW   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int LEVEL_AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic [2:0] K_SET  = 3'd0;
  localparam logic [2:0] K_CLR  = 3'd1;
  localparam logic [2:0] K_TGL  = 3'd2;
  localparam logic [2:0] K_PUSH = 3'd3;
  localparam logic [2:0] K_BASE = 3'd4;
  localparam logic [2:0] K_POP  = 3'd5;
  localparam logic [2:0] K_READ = 3'd6;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] led_index;
    logic [2:0] color_mask;
    logic [1:0] layer;
    logic [2:0] row;
    logic [1:0] plane;
  } in_t;

  typedef struct packed {
    logic            status;
    logic [PB_W-1:0] plane_bits;
  } out_t;

  typedef struct packed {
    logic            status;
    logic [PB_W-1:0] plane_bits;
    logic            led_we;
    logic [LT_W-1:0] led_wdata;
    logic            frame_we;
    logic [FR_W-1:0] frame_wdata;
  } upd_t;

  // Index of the highest set bit of a layer mask, zero for an empty mask.
  function automatic logic [LEVEL_AW-1:0] highest_layer(input logic [LEVELS-1:0] m);
    logic [LEVEL_AW-1:0] h;
    h = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (m[i]) begin
        h = LEVEL_AW'(i);
      end
    end
    return h;
  endfunction

endpackage

// File: src/llmb_ram.sv
// ----------------------------------------------------------------------------
// Layered LED matrix buffer RAM
// Single-port-write, registered-read memory with per-entry valid bits, so
// entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module llmb_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/llmb_update.sv
// ----------------------------------------------------------------------------
// Layered LED matrix buffer update logic
// Works out the new layer entry, the new frame row and the result of one
// command from the two rows read out of the memories.
// ----------------------------------------------------------------------------
module llmb_update (
  input  llmb_pkg::in_t               cmd,
  input  logic [llmb_pkg::LT_W-1:0]   led_row,
  input  logic [llmb_pkg::FR_W-1:0]   frame_row,
  output llmb_pkg::upd_t              upd
);
  import llmb_pkg::*;

  logic [LEVELS-1:0]         mask, mask_new, lay_bit;
  logic [LEVELS*COLOR_W-1:0] cols, cols_new;
  logic [COLORS-1:0]         px, px_new, cm;
  logic [COL_AW-1:0]         col;
  logic [COLOR_W-1:0]        lay_col;
  logic [FR_W-1:0]           fr_new;
  logic                      led_ok, lay_ok, reject, is_write;

  always_comb begin
    mask     = led_row[LEVELS-1:0];
    cols     = led_row[LT_W-1:LEVELS];
    col      = COL_AW'(cmd.led_index % COLS);
    led_ok   = 32'(cmd.led_index) < NLEDS;
    lay_ok   = 32'(cmd.layer) < LEVELS;
    is_write = cmd.kind <= K_POP;
    cm       = COLORS'(cmd.color_mask);
    for (int i = 0; i < LEVELS; i++) begin
      lay_bit[i] = (32'(cmd.layer) == i);
    end
    lay_col = cols[cmd.layer*COLOR_W +: COLOR_W];
    for (int p = 0; p < COLORS; p++) begin
      px[p] = frame_row[p*COLS + 32'(col)];
    end

    mask_new = mask;
    cols_new = cols;
    px_new   = px;
    reject   = 1'b0;

    unique case (cmd.kind)
      K_SET: px_new = px | cm;
      K_CLR: px_new = px & ~cm;
      K_TGL: px_new = px ^ cm;
      K_PUSH: begin
        if (!lay_ok) begin
          reject = 1'b1;
        end else if (mask == '0) begin
          mask_new = lay_bit;
          cols_new[cmd.layer*COLOR_W +: COLOR_W] = cmd.color_mask;
          px_new = px | cm;
        end else if ((mask & lay_bit) != '0) begin
          reject = 1'b1;
        end else begin
          mask_new = mask | lay_bit;
          cols_new[cmd.layer*COLOR_W +: COLOR_W] = cmd.color_mask;
          // A new top layer replaces whatever colours the LED showed.
          if (32'(highest_layer(mask)) < 32'(cmd.layer)) begin
            px_new = cm;
          end
        end
      end
      K_BASE: begin
        if (cmd.layer != '0) begin
          reject = 1'b1;
        end else begin
          mask_new = LEVELS'(1);
          cols_new[COLOR_W-1:0] = cmd.color_mask;
          px_new = px ^ cm;
        end
      end
      K_POP: begin
        if (!lay_ok) begin
          reject = 1'b1;
        end else begin
          mask_new = mask & ~lay_bit;
          cols_new[cmd.layer*COLOR_W +: COLOR_W] = '0;
          px_new = px & ~COLORS'(lay_col);
          // The popped layer is no longer in the mask, so the old colour
          // table gives the right colour for the highest remaining layer.
          if (mask_new != '0) begin
            px_new = px_new |
                     COLORS'(cols[highest_layer(mask_new)*COLOR_W +: COLOR_W]);
          end
        end
      end
      default: ;
    endcase

    fr_new = frame_row;
    for (int p = 0; p < COLORS; p++) begin
      fr_new[p*COLS + 32'(col)] = px_new[p];
    end

    upd.status      = is_write && (!led_ok || reject);
    upd.plane_bits  = '0;
    if (cmd.kind == K_READ && 32'(cmd.row) < ROWS && 32'(cmd.plane) < COLORS) begin
      upd.plane_bits = PB_W'(frame_row[cmd.plane*COLS +: COLS]);
    end
    upd.led_we      = is_write && led_ok && !reject;
    upd.led_wdata   = {cols_new, mask_new};
    upd.frame_we    = is_write && led_ok && !reject;
    upd.frame_wdata = fr_new;
  end

endmodule

// File: src/layered_led_matrix_buffer.sv
// ----------------------------------------------------------------------------
// Layered LED matrix buffer
// Frame buffer of per-colour row bitmaps with a per-LED stack of priority
// layers, driven by single commands that each give one result item.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                   Handshake
//  -------   ---------------------   -----------------------------------------
//  command   start, busy, in_item    taken on a clock edge with start && !busy
//  result    out_valid, out_item     shown for one cycle, out_valid high
//
// For each item, the accepting edge reads the LED's layer entry and the
// affected frame row from their memories; the next edge writes both back,
// unless the item is a read or is rejected, and registers the result. The
// result is on the ports in the cycle after that, while the block can already
// take the next item; it accepts no new item while busy with the last one.
// Reset is synchronous and active low; it clears the valid bits of both
// memories at once, so no clearing pass is needed. The receiver cannot stall
// the block.
//
module layered_led_matrix_buffer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  llmb_pkg::in_t  in_item,
  output logic           out_valid,
  output llmb_pkg::out_t out_item
);
  import llmb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_r, state_nxt;
  in_t              cmd_r;
  logic             out_valid_r;
  out_t             out_item_r;
  logic             accept;
  logic [FR_AW-1:0] frame_rd_addr, frame_wr_addr;
  logic [LT_W-1:0]  led_row;
  logic [FR_W-1:0]  frame_row;
  upd_t             upd;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  // A read command fetches the requested row; every other command the row
  // holding its LED.
  assign frame_rd_addr = (in_item.kind == K_READ) ? FR_AW'(in_item.row)
                                                  : FR_AW'(in_item.led_index / COLS);
  assign frame_wr_addr = FR_AW'(cmd_r.led_index / COLS);

  llmb_ram #(
    .DEPTH (NLEDS),
    .WIDTH (LT_W)
  ) u_led_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_item.led_index[LED_AW-1:0]),
    .rd_data (led_row),
    .wr_en   (busy && upd.led_we),
    .wr_addr (cmd_r.led_index[LED_AW-1:0]),
    .wr_data (upd.led_wdata)
  );

  llmb_ram #(
    .DEPTH (ROWS),
    .WIDTH (FR_W)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (frame_rd_addr),
    .rd_data (frame_row),
    .wr_en   (busy && upd.frame_we),
    .wr_addr (frame_wr_addr),
    .wr_data (upd.frame_wdata)
  );

  llmb_update u_update (
    .cmd       (cmd_r),
    .led_row   (led_row),
    .frame_row (frame_row),
    .upd       (upd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= busy;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item;
    end
    if (busy) begin
      out_item_r.status     <= upd.status;
      out_item_r.plane_bits <= upd.plane_bits;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Every result follows exactly one execute cycle.
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EXEC))
    else $error("result without an execute cycle");

  // An accepted item always goes on to execute.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not execute");

  // Execution lasts a single cycle.
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("execute state held longer than one cycle");

  // A row read is never rejected.
  a_read_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && cmd_r.kind == K_READ) |=> (out_valid && !out_item.status))
    else $error("row read answered as rejected");

  // Only a row read returns bitmap data.
  a_bits_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && cmd_r.kind != K_READ) |=> (out_item.plane_bits == '0))
    else $error("bitmap data on a command other than a read");

endmodule
